// ===== sv/ufl_pkg.sv =====
// Shared types, constants and helpers for the unicycle feedback linearization block.
package ufl_pkg;

    typedef logic signed [31:0] t_q16;
    typedef logic signed [33:0] t_cord;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_GAIN_X        = 2'd0,
        CFG_GAIN_Y        = 2'd1,
        CFG_HALF_DIAMETER = 2'd2
    } t_cfg_idx;

    localparam logic [15:0] GAIN_RESET   = 16'd256;
    localparam logic [23:0] RADIUS_RESET = 24'd6554;

    // CORDIC start value, 1/K in Q30
    localparam t_cord CORDIC_X0 = 34'sd652032874;
    localparam t_cord HALF_TURN = 34'sd2147483648;
    localparam logic signed [15:0] QUARTER_HEADING = 16'sd16384;

    // atan(2^-i) with a full turn of 2^32
    localparam logic [29:0] ATAN_TBL [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    function automatic t_q16 f_sat32(input logic signed [71:0] v);
        t_q16 r;
        if (v > 72'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -72'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/ufl_in_if.sv =====
// Input sample channel: valid/ready with reference and measured point payload.
interface ufl_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] ref_velocity_x;
    logic signed [31:0] ref_velocity_y;
    logic signed [31:0] ref_position_x;
    logic signed [31:0] ref_position_y;
    logic signed [31:0] robot_position_x;
    logic signed [31:0] robot_position_y;
    logic signed [15:0] heading;

    modport source(output valid, ref_velocity_x, ref_velocity_y, ref_position_x,
                   ref_position_y, robot_position_x, robot_position_y, heading,
                   input ready);
    modport sink(input valid, ref_velocity_x, ref_velocity_y, ref_position_x,
                 ref_position_y, robot_position_x, robot_position_y, heading,
                 output ready);
endinterface

// ===== sv/ufl_out_if.sv =====
// Output command channel: valid/ready with velocity command payload.
interface ufl_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;
    logic               singular;

    modport source(output valid, linear_velocity, angular_velocity, singular,
                   input ready);
    modport sink(input valid, linear_velocity, angular_velocity, singular,
                 output ready);
endinterface

// ===== sv/unicycle_feedback_linearization.sv =====
// Unicycle feedback linearization controller: virtual inputs, CORDIC, inverse matrix, divider.
//
// Usage: samples arrive on i_in (valid/ready); one velocity command per sample
// leaves on o_out in the same order. Gains and radius are written through
// i_cfg_we / i_cfg_idx / i_cfg_data while the pipeline is empty.
// Throughput: one sample per cycle while the receiver keeps o_out.ready high.
// The latency from the input transfer to the earliest output transfer is set
// by the CORDIC rotation stages and the 32-stage restoring divider that forms
// the angular velocity quotient.
// Each stage holds its own valid bit; a stage loads when it is empty or
// when the stage after it moves, so bubbles collapse and i_in.ready stays
// high while any stage ahead has room. When the receiver stalls, results
// hold in the output register and the pipeline fills up behind it before
// i_in.ready drops; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and loads the
// gains with 1.0 and the radius with 6554 (about 0.1 m).
// A zero radius yields zero outputs with singular set.
module unicycle_feedback_linearization
    import ufl_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    ufl_in_if.sink      i_in,
    ufl_out_if.source   o_out
);

    localparam int N     = CORDIC_STAGES;
    localparam int S_NEG = N + 2;
    localparam int S_MUL = N + 3;
    localparam int S_SUM = N + 4;
    localparam int S_DIV = N + 5;
    localparam int S_OUT = N + 38;
    localparam int NT    = N + 39;

    // configuration
    logic [15:0] r_gain_x, r_gain_y;
    logic [23:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_x <= GAIN_RESET;
            r_gain_y <= GAIN_RESET;
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_X:        r_gain_x <= i_cfg_data[15:0];
                CFG_GAIN_Y:        r_gain_y <= i_cfg_data[15:0];
                CFG_HALF_DIAMETER: r_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain and per-stage load enables
    logic [NT-1:0] r_vld;
    logic [NT:0]   w_en;

    assign w_en[NT] = o_out.ready;
    for (genvar k = 0; k < NT; k++) begin : g_en
        assign w_en[k] = ~r_vld[k] | w_en[k+1];
    end
    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NT; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_in.valid : r_vld[k-1];
                end
            end
        end
    end

    // stage 0: position error times gain, heading folded to a half turn
    logic signed [32:0] w_ex, w_ey;
    logic signed [49:0] r_px, r_py;
    t_q16               r_vx, r_vy;
    t_cord              w_z0, r_z0;
    logic               w_flip, r_flip0;

    assign w_ex = 33'(i_in.ref_position_x) - 33'(i_in.robot_position_x);
    assign w_ey = 33'(i_in.ref_position_y) - 33'(i_in.robot_position_y);

    always_comb begin
        w_z0   = t_cord'($signed({i_in.heading, 16'h0000}));
        w_flip = 1'b0;
        if (i_in.heading > QUARTER_HEADING) begin
            w_z0   = w_z0 - HALF_TURN;
            w_flip = 1'b1;
        end else if (i_in.heading < -QUARTER_HEADING) begin
            w_z0   = w_z0 + HALF_TURN;
            w_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_px    <= $signed({1'b0, r_gain_x}) * w_ex;
            r_py    <= $signed({1'b0, r_gain_y}) * w_ey;
            r_vx    <= i_in.ref_velocity_x;
            r_vy    <= i_in.ref_velocity_y;
            r_z0    <= w_z0;
            r_flip0 <= w_flip;
        end
    end

    // stage 1: saturated virtual inputs, CORDIC seed
    t_cord r_cx [N+1];
    t_cord r_cy [N+1];
    t_cord r_cz [N+1];
    logic  r_cf [N+1];
    t_q16  r_cv1 [N+1];
    t_q16  r_cv2 [N+1];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_cv1[0] <= f_sat32(72'(r_vx) + 72'(r_px >>> 8));
            r_cv2[0] <= f_sat32(72'(r_vy) + 72'(r_py >>> 8));
            r_cx[0]  <= CORDIC_X0;
            r_cy[0]  <= '0;
            r_cz[0]  <= r_z0;
            r_cf[0]  <= r_flip0;
        end
    end

    // CORDIC rotation stages
    for (genvar g = 0; g < N; g++) begin : g_cordic
        localparam t_cord ATAN = t_cord'(ATAN_TBL[g]);
        always_ff @(posedge i_clk) begin
            if (w_en[2+g]) begin
                if (!r_cz[g][33]) begin
                    r_cx[g+1] <= r_cx[g] - (r_cy[g] >>> g);
                    r_cy[g+1] <= r_cy[g] + (r_cx[g] >>> g);
                    r_cz[g+1] <= r_cz[g] - ATAN;
                end else begin
                    r_cx[g+1] <= r_cx[g] + (r_cy[g] >>> g);
                    r_cy[g+1] <= r_cy[g] - (r_cx[g] >>> g);
                    r_cz[g+1] <= r_cz[g] + ATAN;
                end
                r_cf[g+1]  <= r_cf[g];
                r_cv1[g+1] <= r_cv1[g];
                r_cv2[g+1] <= r_cv2[g];
            end
        end
    end

    // undo the half-turn fold
    t_cord r_cos, r_sin;
    t_q16  r_nv1, r_nv2;

    always_ff @(posedge i_clk) begin
        if (w_en[S_NEG]) begin
            r_cos <= r_cf[N] ? -r_cx[N] : r_cx[N];
            r_sin <= r_cf[N] ? -r_cy[N] : r_cy[N];
            r_nv1 <= r_cv1[N];
            r_nv2 <= r_cv2[N];
        end
    end

    // matrix products
    logic signed [65:0] r_p_cv1, r_p_sv2, r_p_cv2, r_p_sv1;

    always_ff @(posedge i_clk) begin
        if (w_en[S_MUL]) begin
            r_p_cv1 <= r_cos * r_nv1;
            r_p_sv2 <= r_sin * r_nv2;
            r_p_cv2 <= r_cos * r_nv2;
            r_p_sv1 <= r_sin * r_nv1;
        end
    end

    logic signed [66:0] r_lin_sum, r_num;

    always_ff @(posedge i_clk) begin
        if (w_en[S_SUM]) begin
            r_lin_sum <= 67'(r_p_cv1) + 67'(r_p_sv2);
            r_num     <= 67'(r_p_cv2) - 67'(r_p_sv1);
        end
    end

    // divider setup: magnitude, sign, quotient overflow beyond 32 bits
    logic [37:0] w_den;
    logic [69:0] w_den_top;
    logic [66:0] w_mag;

    assign w_den     = {r_radius, 14'h0000};
    assign w_den_top = {w_den, 32'h0000_0000};
    assign w_mag     = r_num[66] ? $unsigned(-r_num) : $unsigned(r_num);

    logic [69:0] r_rem [33];
    logic [31:0] r_quo [33];
    t_q16        r_lin [33];
    logic        r_neg [33];
    logic        r_ovf [33];

    always_ff @(posedge i_clk) begin
        if (w_en[S_DIV]) begin
            r_lin[0] <= f_sat32(72'(r_lin_sum >>> 30));
            r_neg[0] <= r_num[66];
            r_ovf[0] <= {3'b000, w_mag} >= w_den_top;
            r_rem[0] <= {3'b000, w_mag};
            r_quo[0] <= '0;
        end
    end

    // restoring division, one quotient bit per stage, MSB first
    for (genvar t = 0; t < 32; t++) begin : g_div
        logic [69:0] w_sub;
        assign w_sub = 70'(w_den) << (31 - t);
        always_ff @(posedge i_clk) begin
            if (w_en[S_DIV+1+t]) begin
                if (r_rem[t] >= w_sub) begin
                    r_rem[t+1] <= r_rem[t] - w_sub;
                    r_quo[t+1] <= r_quo[t] | (32'h8000_0000 >> t);
                end else begin
                    r_rem[t+1] <= r_rem[t];
                    r_quo[t+1] <= r_quo[t];
                end
                r_lin[t+1] <= r_lin[t];
                r_neg[t+1] <= r_neg[t];
                r_ovf[t+1] <= r_ovf[t];
            end
        end
    end

    // output register: sign, saturation, singular override
    t_q16 w_ang;
    t_q16 r_out_lin, r_out_ang;
    logic r_out_sing;

    always_comb begin
        if (r_neg[32]) begin
            if (r_ovf[32] || r_quo[32] > 32'h8000_0000) begin
                w_ang = 32'sh80000000;
            end else begin
                w_ang = -$signed(r_quo[32]);
            end
        end else begin
            if (r_ovf[32] || r_quo[32][31]) begin
                w_ang = 32'sh7FFFFFFF;
            end else begin
                w_ang = $signed(r_quo[32]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_OUT]) begin
            if (r_radius == '0) begin
                r_out_lin  <= '0;
                r_out_ang  <= '0;
                r_out_sing <= 1'b1;
            end else begin
                r_out_lin  <= r_lin[32];
                r_out_ang  <= w_ang;
                r_out_sing <= 1'b0;
            end
        end
    end

    assign o_out.valid            = r_vld[S_OUT];
    assign o_out.linear_velocity  = r_out_lin;
    assign o_out.angular_velocity = r_out_ang;
    assign o_out.singular         = r_out_sing;

    // checks
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.singular |->
            o_out.linear_velocity == '0 && o_out.angular_velocity == '0)
        else $error("singular result with nonzero outputs");

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> i_in.ready)
        else $error("input stalled with first stage empty");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && w_en[1] |=> r_vld[1])
        else $error("item dropped between first stages");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted transfer not captured");

endmodule
